### rtl/cms_pkg.sv
// Shared types and constants of the CAN multi-frame segmenter.
`timescale 1ns / 1ps
`default_nettype none
package cms_pkg;

  localparam int BYTES_PER_SEGMENT  = 7;
  localparam int SINGLE_FRAME_LIMIT = 8;
  localparam int FRAME_BYTES        = 8;
  localparam int POS_W              = $clog2(FRAME_BYTES);

  localparam int ID_W    = 11;
  localparam int LEN_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int DLC_W   = 4;
  localparam int NIB_W   = 4;
  localparam int FILL_W  = 4;

  // floor(x / BYTES_PER_SEGMENT) as (x * RECIP) >> RECIP_SHIFT, exact for x < 2**(LEN_W+1)
  localparam int RECIP_SHIFT = 14;
  localparam int RECIP       = (2**RECIP_SHIFT + BYTES_PER_SEGMENT - 1) / BYTES_PER_SEGMENT;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int SUM_W       = LEN_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 80;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    byte_t            data;
    logic             emit;
    logic             hdr_en;
    byte_t            header;
    logic [DLC_W-1:0] dlc;
    logic [ID_W-1:0]  id;
    logic             last;
  } q_item_t;

endpackage
`default_nettype wire

### rtl/cms_front.sv
// Front end: accepts payload bytes, tracks message and frame position, classifies each byte.
`timescale 1ns / 1ps
`default_nettype none
module cms_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [cms_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                                 push_o,
  output cms_pkg::q_item_t                     item_o,
  input  wire logic                            full_i
);
  import cms_pkg::*;

  logic [LEN_W-1:0]  bytes_left_q, bytes_left_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [NIB_W-1:0]  fidx_q, fidx_d;
  logic [NIB_W-1:0]  lidx_q, lidx_d;
  logic              multi_q, multi_d;
  logic [ID_W-1:0]   id_q, id_d;

  logic [ID_W-1:0]   in_id;
  logic [LEN_W-1:0]  in_len;
  byte_t             in_byte;
  logic              start;
  logic [LEN_W-1:0]  len_eff;
  logic [SUM_W-1:0]  len_sum;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [LEN_W-1:0]  cur_left, left_n;
  logic              cur_multi;
  logic [FILL_W-1:0] cur_fill, fill_n, dlc_raw;
  logic [NIB_W-1:0]  cur_fidx, cur_lidx;
  logic [ID_W-1:0]   cur_id;
  logic              emit, last, accept;

  assign in_id   = s_axis_tdata[ID_W-1:0];
  assign in_len  = s_axis_tdata[ID_W +: LEN_W];
  assign in_byte = s_axis_tdata[ID_W+LEN_W +: BYTE_W];

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_o        = accept;

  always_comb begin
    start     = (bytes_left_q == '0);
    len_eff   = (in_len == '0) ? LEN_W'(1) : in_len;
    len_sum   = SUM_W'(len_eff) + SUM_W'(BYTES_PER_SEGMENT - 1);
    prod      = PROD_W'(len_sum) * PROD_W'(RECIP);
    quot      = prod[PROD_W-1:RECIP_SHIFT];
    cur_left  = start ? len_eff : bytes_left_q;
    cur_multi = start ? (len_eff > LEN_W'(SINGLE_FRAME_LIMIT)) : multi_q;
    cur_fill  = start ? '0 : fill_q;
    cur_fidx  = start ? '0 : fidx_q;
    cur_lidx  = start ? NIB_W'(quot - QUOT_W'(1)) : lidx_q;
    cur_id    = start ? in_id : id_q;
    fill_n    = cur_fill + FILL_W'(1);
    left_n    = cur_left - LEN_W'(1);
    last      = (left_n == '0);
    emit      = last
             || (!cur_multi && fill_n >= FILL_W'(SINGLE_FRAME_LIMIT))
             || (cur_multi && fill_n >= FILL_W'(BYTES_PER_SEGMENT));
    dlc_raw   = cur_multi ? fill_n + FILL_W'(1) : fill_n;

    item_o.pos    = cur_multi ? POS_W'(fill_n) : POS_W'(cur_fill);
    item_o.data   = in_byte;
    item_o.emit   = emit;
    item_o.hdr_en = cur_multi;
    item_o.header = {cur_lidx, cur_fidx};
    item_o.dlc    = (dlc_raw > FILL_W'(FRAME_BYTES)) ? DLC_W'(FRAME_BYTES) : DLC_W'(dlc_raw);
    item_o.id     = cur_id;
    item_o.last   = last;

    bytes_left_d = bytes_left_q;
    fill_d       = fill_q;
    fidx_d       = fidx_q;
    lidx_d       = lidx_q;
    multi_d      = multi_q;
    id_d         = id_q;
    if (accept) begin
      bytes_left_d = left_n;
      lidx_d       = cur_lidx;
      id_d         = cur_id;
      multi_d      = cur_multi && !last;
      fill_d       = emit ? '0 : fill_n;
      if (last) begin
        fidx_d = '0;
      end else if (emit) begin
        fidx_d = cur_fidx + NIB_W'(1);
      end else begin
        fidx_d = cur_fidx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      fill_q       <= '0;
      fidx_q       <= '0;
      lidx_q       <= '0;
      multi_q      <= 1'b0;
      id_q         <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      fill_q       <= fill_d;
      fidx_q       <= fidx_d;
      lidx_q       <= lidx_d;
      multi_q      <= multi_d;
      id_q         <= id_d;
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_left_q == '0) |-> (fill_q == '0 && fidx_q == '0 && !multi_q))
    else $error("idle front holds leftover frame state");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FILL_W'(SINGLE_FRAME_LIMIT))
    else $error("frame fill overran its frame");

endmodule
`default_nettype wire

### rtl/cms_queue.sv
// Short queue between front end and frame builder.
`timescale 1ns / 1ps
`default_nettype none
module cms_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  cms_pkg::q_item_t item_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output cms_pkg::q_item_t item_o
);
  import cms_pkg::*;

  q_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule
`default_nettype wire

### rtl/cms_back.sv
// Frame builder: places classified bytes and emits finished frames.
`timescale 1ns / 1ps
`default_nettype none
module cms_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  cms_pkg::q_item_t                    item_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [cms_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast
);
  import cms_pkg::*;

  byte_t             frame_q [FRAME_BYTES];
  byte_t             frame_d [FRAME_BYTES];
  byte_t             done_bytes [FRAME_BYTES];
  byte_t             out_bytes_q [FRAME_BYTES];
  logic [ID_W-1:0]   out_id_q;
  logic [DLC_W-1:0]  out_dlc_q;
  logic              out_last_q;
  logic              out_valid_q, out_valid_d;
  logic              load;

  assign pop_o = valid_i && (!item_i.emit || !out_valid_q || m_axis_tready);
  assign load  = pop_o && item_i.emit;

  always_comb begin
    for (int k = 0; k < FRAME_BYTES; k++) begin
      done_bytes[k] = frame_q[k];
      frame_d[k]    = frame_q[k];
    end
    done_bytes[item_i.pos] = item_i.data;
    if (item_i.hdr_en) begin
      done_bytes[0] = item_i.header;
    end
    if (pop_o) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        frame_d[k] = item_i.emit ? '0 : done_bytes[k];
      end
    end
    out_valid_d = load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        frame_q[k] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        frame_q[k] <= frame_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_id_q   <= item_i.id;
      out_dlc_q  <= item_i.dlc;
      out_last_q <= item_i.last;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        out_bytes_q[k] <= done_bytes[k];
      end
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[ID_W-1:0] = out_id_q;
    m_axis_tdata[ID_W +: DLC_W] = out_dlc_q;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      m_axis_tdata[ID_W + DLC_W + k*BYTE_W +: BYTE_W] = out_bytes_q[k];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;

  a_dlc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_dlc_q != '0 && out_dlc_q <= DLC_W'(FRAME_BYTES)))
    else $error("frame length code out of range");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (frame_q[FRAME_BYTES-1] == '0))
    else $error("frame buffer not cleared after emit");

endmodule
`default_nettype wire

### rtl/can_multiframe_segmenter_unit.sv
// Top level of the CAN multi-frame segmenter.
// Takes one payload byte per transaction (identifier and length are sampled on the
// first byte of a message) and returns CAN data frames: messages of up to 8 bytes
// as one plain frame, longer ones as 7-byte segments behind a header byte with the
// last frame index in the high nibble and the current index in the low nibble.
// One byte per cycle is sustained while the master side takes frames; an accepted byte
// is written into a two-entry queue between the front end and the frame builder, which
// absorbs output stalls, and reaches the master side from the builder's output register.
`timescale 1ns / 1ps
`default_nettype none
module can_multiframe_segmenter_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // frame_id[10:0], message_length[18:11], payload_byte[26:19], zero pad
  input  wire logic [cms_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_id[10:0], data_length_code[14:11], byte0..byte7[78:15], zero pad
  output logic [cms_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast
);
  import cms_pkg::*;

  logic    push, full, pop, q_valid;
  q_item_t push_item, pop_item;

  cms_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .item_o        (push_item),
    .full_i        (full)
  );

  cms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  cms_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire
